>>> hdl/sww_pkg.sv
`timescale 1ns / 1ps
// Package for the share work window: field widths, commands, status codes.
// Used by every module of the block; depends on nothing.
package sww_pkg;

    localparam int SHARE_DEPTH_DEF    = 8192;
    localparam int IDENTITY_COUNT_DEF = 4096;
    localparam int WORK_W     = 64;
    localparam int ID_W       = 12;
    localparam int CNT_OUT_W  = 14;

    localparam logic CMD_RECORD = 1'b0;
    localparam logic CMD_RETRIM = 1'b1;

    localparam logic ST_ACCEPTED = 1'b0;
    localparam logic ST_REJECTED = 1'b1;

endpackage

>>> hdl/share_work_window.sv
`timescale 1ns / 1ps
// Top level of the share work window: share ring, tally memory and trim sequencer.
// Depends on sww_pkg.
//
// Channel   | Direction | Handshake          | Content
// ----------+-----------+--------------------+--------------------------------------------
// input     | in        | in_valid/in_stall  | cmd, identity, difficulty
// result    | out       | out_valid/out_stall| status, window_total, share_count,
//           |           |                    | identity_work, dropped
// config    | in        | cfg_valid/cfg_ready| cfg_data (window_limit)
//
// A record appends its share, adds it to its identity's tally and trims; a full ring
// first drops its oldest share. The trim drops oldest shares while more than one is held,
// the total exceeds the limit and the oldest is no larger than the excess. A rejected
// share goes straight to its result; a retrim runs only the trim. Each drop is a ring read
// followed by a tally read-modify-write, one memory port each. After reset a clearing pass
// zeroes the whole tally memory; no item is taken during it. One item is worked on at a
// time; the next is taken in idle once the result register is empty or being read out.
module share_work_window
    import sww_pkg::*;
#(
    parameter int SHARE_DEPTH    = SHARE_DEPTH_DEF,
    parameter int IDENTITY_COUNT = IDENTITY_COUNT_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 cmd,
    input  logic [ID_W-1:0]      identity,
    input  logic [WORK_W-1:0]    difficulty,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 status,
    output logic [WORK_W-1:0]    window_total,
    output logic [CNT_OUT_W-1:0] share_count,
    output logic [WORK_W-1:0]    identity_work,
    output logic [CNT_OUT_W-1:0] dropped,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [WORK_W-1:0]    cfg_data
);

    localparam int SA_W = (SHARE_DEPTH > 1) ? $clog2(SHARE_DEPTH) : 1;
    localparam int HC_W = $clog2(SHARE_DEPTH + 1);
    localparam int TA_W = (IDENTITY_COUNT > 1) ? $clog2(IDENTITY_COUNT) : 1;
    localparam int TC_W = $clog2(IDENTITY_COUNT + 1);

    typedef enum logic [9:0] {
        S_CLEAR   = 10'b0000000001,
        S_IDLE    = 10'b0000000010,
        S_FULLRD  = 10'b0000000100,
        S_APPEND  = 10'b0000001000,
        S_TADD    = 10'b0000010000,
        S_TRIMCHK = 10'b0000100000,
        S_TRIMRD  = 10'b0001000000,
        S_DROPRD  = 10'b0010000000,
        S_DROPWR  = 10'b0100000000,
        S_FINRD   = 10'b1000000000
    } state_t;

    // Ring memories and tally memory.
    logic [WORK_W-1:0] ring_diff_mem [SHARE_DEPTH];
    logic [ID_W-1:0]   ring_own_mem  [SHARE_DEPTH];
    logic [WORK_W-1:0] tally_mem     [IDENTITY_COUNT];

    state_t            state_reg, state_next;
    logic [SA_W-1:0]   oldest_reg, oldest_next;
    logic [HC_W-1:0]   held_reg, held_next;
    logic [WORK_W-1:0] total_reg, total_next;
    logic [WORK_W-1:0] limit_reg;
    logic [TC_W-1:0]   clr_reg, clr_next;
    logic              full_drop_reg, full_drop_next;
    logic              cmd_reg;
    logic [ID_W-1:0]   id_reg;
    logic [WORK_W-1:0] diff_reg;
    logic [HC_W-1:0]   drop_cnt_reg, drop_cnt_next;
    logic              out_valid_reg;
    logic              status_reg;
    logic [WORK_W-1:0] total_out_reg, ident_out_reg;
    logic [CNT_OUT_W-1:0] count_out_reg, drop_out_reg;

    // Memory port controls.
    logic              ring_we;
    logic [SA_W-1:0]   ring_addr;
    logic [WORK_W-1:0] ring_rd_diff;
    logic [ID_W-1:0]   ring_rd_own;
    logic              tally_we;
    logic [TA_W-1:0]   tally_addr;
    logic [WORK_W-1:0] tally_wdata, tally_rd;
    logic [ID_W-1:0]   tally_id;
    logic              tally_hit;

    logic              accept;
    logic              done;
    logic [SA_W:0]     slot_sum;
    logic [SA_W-1:0]   append_slot;
    logic [SA_W-1:0]   oldest_inc;
    logic [WORK_W-1:0] excess;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = !(state_reg == S_IDLE) || (out_valid_reg && out_stall);
    assign cfg_ready = (state_reg == S_IDLE);

    // Ring slot arithmetic: oldest plus held, and oldest plus one, modulo the depth.
    always_comb
    begin
        slot_sum = {1'b0, oldest_reg} + (SA_W+1)'(held_reg);
        if (slot_sum >= (SA_W+1)'(SHARE_DEPTH))
        begin
            slot_sum = slot_sum - (SA_W+1)'(SHARE_DEPTH);
        end
        append_slot = slot_sum[SA_W-1:0];
        if (oldest_reg == SA_W'(SHARE_DEPTH - 1))
        begin
            oldest_inc = '0;
        end
        else
        begin
            oldest_inc = oldest_reg + SA_W'(1);
        end
        excess = total_reg - limit_reg;
    end

    // Ring memory with registered read.
    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_diff_mem[ring_addr] <= diff_reg;
            ring_own_mem[ring_addr]  <= id_reg;
        end
        ring_rd_diff <= ring_diff_mem[ring_addr];
        ring_rd_own  <= ring_own_mem[ring_addr];
    end

    // Tally memory with registered read.
    always_ff @(posedge clk)
    begin
        if (tally_we)
        begin
            tally_mem[tally_addr] <= tally_wdata;
        end
        tally_rd <= tally_mem[tally_addr];
    end

    assign tally_hit = (32'(tally_id) < 32'(IDENTITY_COUNT));

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        oldest_next    = oldest_reg;
        held_next      = held_reg;
        total_next     = total_reg;
        clr_next       = clr_reg;
        full_drop_next = full_drop_reg;
        drop_cnt_next  = drop_cnt_reg;
        ring_we        = 1'b0;
        ring_addr      = oldest_reg;
        tally_we       = 1'b0;
        tally_id       = id_reg;
        tally_wdata    = '0;
        done           = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                tally_we = 1'b1;
                clr_next = clr_reg + TC_W'(1);
                if (clr_reg == TC_W'(IDENTITY_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                tally_id = identity;
                if (accept)
                begin
                    drop_cnt_next  = '0;
                    full_drop_next = 1'b0;
                    if (cmd == CMD_RETRIM)
                    begin
                        state_next = S_TRIMCHK;
                    end
                    else if (difficulty == '0)
                    begin
                        state_next = S_FINRD;
                    end
                    else if (held_reg == HC_W'(SHARE_DEPTH))
                    begin
                        state_next = S_FULLRD;
                    end
                    else
                    begin
                        state_next = S_APPEND;
                    end
                end
            end
            S_FULLRD:
            begin
                // Read the oldest share to drop it before the append.
                full_drop_next = 1'b1;
                state_next     = S_DROPRD;
            end
            S_APPEND:
            begin
                ring_we    = 1'b1;
                ring_addr  = append_slot;
                held_next  = held_reg + HC_W'(1);
                total_next = total_reg + diff_reg;
                state_next = S_TADD;
            end
            S_TADD:
            begin
                // The tally was read during the append cycle.
                tally_we    = tally_hit;
                tally_wdata = tally_rd + diff_reg;
                state_next  = S_TRIMCHK;
            end
            S_TRIMCHK:
            begin
                if (held_reg > HC_W'(1) && total_reg > limit_reg)
                begin
                    state_next = S_TRIMRD;
                end
                else
                begin
                    state_next = S_FINRD;
                end
            end
            S_TRIMRD:
            begin
                // ring_rd_* now holds the oldest share.
                if (ring_rd_diff > excess)
                begin
                    state_next = S_FINRD;
                end
                else
                begin
                    state_next = S_DROPRD;
                end
            end
            S_DROPRD:
            begin
                tally_id   = ring_rd_own;
                total_next = (total_reg >= ring_rd_diff) ? total_reg - ring_rd_diff : '0;
                state_next = S_DROPWR;
            end
            S_DROPWR:
            begin
                tally_id      = ring_rd_own;
                tally_we      = tally_hit;
                tally_wdata   = (tally_rd >= ring_rd_diff) ? tally_rd - ring_rd_diff : '0;
                oldest_next   = oldest_inc;
                held_next     = held_reg - HC_W'(1);
                drop_cnt_next = drop_cnt_reg + HC_W'(1);
                if (full_drop_reg)
                begin
                    full_drop_next = 1'b0;
                    state_next     = S_APPEND;
                end
                else
                begin
                    state_next = S_TRIMCHK;
                end
            end
            S_FINRD:
            begin
                // Tally of the input identity was read in the previous cycle's address.
                done       = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        // The clearing pass walks the whole tally memory by its own counter.
        if (state_reg == S_CLEAR)
        begin
            tally_addr = TA_W'(clr_reg);
        end
        else
        begin
            tally_addr = TA_W'(tally_id);
        end
    end

    // The final tally read needs the input identity on the address in the cycle before:
    // TRIMCHK and TRIMRD leading to FINRD keep id_reg on the tally address, and the
    // zero-difficulty path reads it from IDLE.

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            oldest_reg    <= '0;
            held_reg      <= '0;
            total_reg     <= '0;
            limit_reg     <= WORK_W'(1);
            clr_reg       <= '0;
            full_drop_reg <= 1'b0;
            drop_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            oldest_reg    <= oldest_next;
            held_reg      <= held_next;
            total_reg     <= total_next;
            clr_reg       <= clr_next;
            full_drop_reg <= full_drop_next;
            drop_cnt_reg  <= drop_cnt_next;
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= (cfg_data == '0) ? WORK_W'(1) : cfg_data;
            end
            if (done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Item and result payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= cmd;
            id_reg   <= identity;
            diff_reg <= difficulty;
        end
        if (done)
        begin
            status_reg    <= (cmd_reg == CMD_RECORD && diff_reg == '0) ? ST_REJECTED
                                                                       : ST_ACCEPTED;
            total_out_reg <= total_reg;
            count_out_reg <= CNT_OUT_W'(held_reg);
            ident_out_reg <= tally_hit ? tally_rd : '0;
            drop_out_reg  <= CNT_OUT_W'(drop_cnt_reg);
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign window_total  = total_out_reg;
    assign share_count   = count_out_reg;
    assign identity_work = ident_out_reg;
    assign dropped       = drop_out_reg;

    // A held result is never overwritten while it waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(window_total))
        else $error("result lost while stalled");

    // No more shares are held than the ring has slots.
    assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= HC_W'(SHARE_DEPTH))
        else $error("held count exceeds ring depth");

    // Items are taken only from idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> state_reg == S_IDLE)
        else $error("item taken while busy");

    // A drop always removes exactly one share.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DROPWR |=> held_reg == $past(held_reg) - HC_W'(1))
        else $error("drop miscounted");

endmodule

>>> tb/share_work_window_tb.sv
`timescale 1ns / 1ps
// Testbench for share_work_window: drives records and retrims against a built-in window model.
// Depends on sww_pkg and the share_work_window RTL.
module share_work_window_tb;
    import sww_pkg::*;

    localparam int DEPTH = SHARE_DEPTH_DEF;
    localparam int IDS   = IDENTITY_COUNT_DEF;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic                 st;
        logic [WORK_W-1:0]    total;
        logic [CNT_OUT_W-1:0] count;
        logic [WORK_W-1:0]    id_work;
        logic [CNT_OUT_W-1:0] drops;
    } window_result_t;

    // Window model and queue of expected results.
    class window_scoreboard;
        logic [WORK_W-1:0] limit;
        logic [WORK_W-1:0] ring_diff [DEPTH];
        logic [ID_W-1:0]   ring_id [DEPTH];
        int                oldest;
        int                held;
        logic [WORK_W-1:0] total;
        logic [WORK_W-1:0] tally [IDS];
        window_result_t    pending [$];
        int                errors;

        function new();
            limit = 1;
            oldest = 0;
            held = 0;
            total = 0;
            errors = 0;
            foreach (tally[i]) tally[i] = 0;
        endfunction

        function void set_limit(logic [WORK_W-1:0] v);
            limit = (v == 0) ? 1 : v;
        endfunction

        function void retire_first();
            logic [WORK_W-1:0] d;
            d = ring_diff[oldest];
            total = (total >= d) ? total - d : 0;
            tally[ring_id[oldest]] = (tally[ring_id[oldest]] >= d) ?
                tally[ring_id[oldest]] - d : 0;
            oldest = (oldest + 1) % DEPTH;
            held--;
        endfunction

        function int trim();
            int n;
            n = 0;
            while (held > 1 && total > limit) begin
                if (ring_diff[oldest] > total - limit) break;
                retire_first();
                n++;
            end
            return n;
        endfunction

        // Works out the result of one accepted item.
        function void note_item(logic c, logic [ID_W-1:0] id, logic [WORK_W-1:0] d);
            window_result_t r;
            int n;
            int slot;
            n = 0;
            r.st = ST_ACCEPTED;
            if (c == CMD_RETRIM) n = trim();
            else if (d == 0) r.st = ST_REJECTED;
            else begin
                if (held >= DEPTH) begin
                    retire_first();
                    n++;
                end
                slot = (oldest + held) % DEPTH;
                ring_diff[slot] = d;
                ring_id[slot] = id;
                held++;
                total = total + d;
                tally[id] = tally[id] + d;
                n += trim();
            end
            r.total = total;
            r.count = held[CNT_OUT_W-1:0];
            r.id_work = tally[id];
            r.drops = n[CNT_OUT_W-1:0];
            pending.push_back(r);
        endfunction

        function void check_result(window_result_t a);
            window_result_t e;
            if (pending.size() == 0) begin
                $error("result with no item pending");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.st !== e.st) begin
                $error("status: expected %0d, got %0d", e.st, a.st); errors++;
            end
            if (a.total !== e.total) begin
                $error("window_total: expected %0d, got %0d", e.total, a.total); errors++;
            end
            if (a.count !== e.count) begin
                $error("share_count: expected %0d, got %0d", e.count, a.count); errors++;
            end
            if (a.id_work !== e.id_work) begin
                $error("identity_work: expected %0d, got %0d", e.id_work, a.id_work);
                errors++;
            end
            if (a.drops !== e.drops) begin
                $error("dropped: expected %0d, got %0d", e.drops, a.drops); errors++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic                 cmd;
    logic [ID_W-1:0]      identity;
    logic [WORK_W-1:0]    difficulty;
    logic                 out_valid;
    logic                 out_stall;
    logic                 status;
    logic [WORK_W-1:0]    window_total;
    logic [CNT_OUT_W-1:0] share_count;
    logic [WORK_W-1:0]    identity_work;
    logic [CNT_OUT_W-1:0] dropped;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [WORK_W-1:0]    cfg_data;

    window_scoreboard sb;
    int  send_idle_pct;
    int  recv_stall_pct;
    int  hold_cycles;
    longint cycles;

    share_work_window u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .cmd(cmd), .identity(identity), .difficulty(difficulty),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .window_total(window_total), .share_count(share_count),
        .identity_work(identity_work), .dropped(dropped),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Cycle counter with a run limit.
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Receiver: random stall, or a long hold-off counted here.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) out_stall <= 1'b1;
        else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            out_stall <= 1'b1;
        end
        else out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Checks each accepted result item.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result({status, window_total, share_count, identity_work, dropped});
    end

    // Offers one item and waits until it is accepted; valid stays up for the next item.
    task automatic send_item(logic c, logic [ID_W-1:0] id, logic [WORK_W-1:0] d);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        identity <= id;
        difficulty <= d;
        do @(posedge clk); while (in_stall);
        sb.note_item(c, id, d);
    endtask

    // Stops offering items and waits for every expected result.
    task automatic wait_drained();
        if (in_valid) in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // Writes the window limit while the block is idle.
    task automatic write_limit(logic [WORK_W-1:0] v);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_limit(v);
    endtask

    function automatic logic [WORK_W-1:0] rand_diff();
        case ($urandom_range(9))
            0: return {$urandom, $urandom};
            1: return 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(3);
            2: return 0;
            default: return $urandom_range(1, 1000);
        endcase
    endfunction

    task automatic random_items(int n);
        for (int i = 0; i < n; i++)
            send_item(($urandom_range(9) == 0) ? CMD_RETRIM : CMD_RECORD,
                      ($urandom_range(3) == 0) ? ID_W'($urandom) : ID_W'($urandom_range(7)),
                      rand_diff());
    endtask

    initial
    begin
        sb = new();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        cmd = CMD_RECORD;
        identity = '0;
        difficulty = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: zero and extreme difficulty, extreme identities, retrim, wrap.
        send_item(CMD_RECORD, 0, 0);
        send_item(CMD_RETRIM, 12'hFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(CMD_RECORD, 12'hFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(CMD_RECORD, 0, 1);
        send_item(CMD_RECORD, 12'hFFF, 2);
        write_limit(64'hFFFF_FFFF_FFFF_FFFF);
        send_item(CMD_RECORD, 5, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(CMD_RECORD, 5, 64'h8000_0000_0000_0000);
        send_item(CMD_RECORD, 6, 10);
        write_limit(0);
        send_item(CMD_RETRIM, 5, 0);
        send_item(CMD_RECORD, 7, 3);
        write_limit(100);
        for (int i = 0; i < 10; i++) send_item(CMD_RECORD, ID_W'(i), 30);
        send_item(CMD_RECORD, 1, 0);
        write_limit(45);
        send_item(CMD_RETRIM, 2, 1);

        // Random phases over idling patterns and limits.
        write_limit(500);
        random_items(150);
        send_idle_pct = 84;
        random_items(120);
        write_limit(64'hFFFF_FFFF_FFFF_FFFF);
        send_idle_pct = 0;
        recv_stall_pct = 84;
        random_items(120);
        write_limit(2000);
        send_idle_pct = 11;
        recv_stall_pct = 11;
        random_items(150);
        // Long receiver hold-off while items keep coming, then a full drain.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 300;
        random_items(60);
        wait_drained();
        write_limit(1);
        random_items(130);

        wait_drained();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> files.f
hdl/sww_pkg.sv
hdl/share_work_window.sv
tb/share_work_window_tb.sv
